/* design/bcd_pkg.sv */
// Package: shared types, constants and arithmetic helpers for the block decoder
`timescale 1ns / 1ps
package bcd_pkg;

    localparam logic [1:0] FMT_BC1 = 2'd0;
    localparam logic [1:0] FMT_BC2 = 2'd1;
    localparam logic [1:0] FMT_BC3 = 2'd2;

    typedef logic [7:0] chan_t;
    typedef chan_t [2:0] rgb_t;
    typedef rgb_t [3:0] palette_t;
    typedef chan_t [7:0] alpha_tab_t;

    // integer divide by 3 for values below 766, by reciprocal
    function automatic chan_t div3(input logic [9:0] v);
        logic [21:0] prod;
        begin
            prod = v * 12'd2731;
            div3 = prod[20:13];
        end
    endfunction

    // divide by 7 for values below 1786
    function automatic chan_t div7(input logic [10:0] v);
        logic [24:0] prod;
        begin
            prod = v * 14'd9363;
            div7 = prod[23:16];
        end
    endfunction

    // divide by 5 for values below 1276
    function automatic chan_t div5(input logic [10:0] v);
        logic [24:0] prod;
        begin
            prod = v * 14'd6554;
            div5 = prod[22:15];
        end
    endfunction

    function automatic rgb_t expand565(input logic [15:0] c);
        rgb_t o;
        begin
            o[0] = {c[15:11], c[15:13]};
            o[1] = {c[10:5], c[10:9]};
            o[2] = {c[4:0], c[4:2]};
            expand565 = o;
        end
    endfunction

endpackage

/* design/bcd_if.sv */
// Interfaces: valid/ready channels for blocks, rows and configuration
`timescale 1ns / 1ps
interface bcd_block_if;
    logic        valid;
    logic        ready;
    logic [63:0] alpha_word;
    logic [63:0] color_word;
    modport source (output valid, alpha_word, color_word, input ready);
    modport sink (input valid, alpha_word, color_word, output ready);
endinterface

interface bcd_row_if;
    logic        valid;
    logic        ready;
    logic [1:0]  row_index;
    logic [31:0] pixel_col0;
    logic [31:0] pixel_col1;
    logic [31:0] pixel_col2;
    logic [31:0] pixel_col3;
    logic        last_row;
    modport source (output valid, row_index, pixel_col0, pixel_col1, pixel_col2,
                    pixel_col3, last_row, input ready);
    modport sink (input valid, row_index, pixel_col0, pixel_col1, pixel_col2,
                  pixel_col3, last_row, output ready);
endinterface

interface bcd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* design/bc1_bc2_bc3_block_decoder_top.sv */
// Top level: BC1/BC2/BC3 block decoder with pipeline and row serialiser
`timescale 1ns / 1ps
// Decodes one compressed 4x4 block into four rows of RGBA8888 pixels, rows
// 0..3 in order with last_row on row 3. The pipeline has three register
// stages (endpoint expansion, palette and alpha table, pixel select) feeding
// a row serialiser that holds one decoded block; blocks enter back to back
// unless a decoded block waits for the serialiser, and the output moves one
// row per cycle while row.ready is high. Code 3 decodes as BC3. A block passes
// the stages and the serialiser before its first row. block_format must be written
// through the configuration channel only while the block is idle; the block itself does not enforce this.
module bc1_bc2_bc3_block_decoder_top (
    input logic clk,
    input logic rst_n,
    bcd_cfg_if.sink     cfg,
    bcd_block_if.sink   blk,
    bcd_row_if.source   row
);
    import bcd_pkg::*;

    logic [1:0] fmt_reg;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_BC3;
        end
        else if (cfg.valid)
        begin
            fmt_reg <= cfg.data;
        end
    end

    // serialiser: holds one block, emits a row per handshake
    logic         busy_reg;
    logic [1:0]   row_reg;
    logic [511:0] blk_reg;
    logic         adv;
    logic         p_valid;
    logic [511:0] p_pix;
    logic         take;
    logic         drain_done;

    assign drain_done = row.valid && row.ready && (row_reg == 2'd3);
    assign take = p_valid && (!busy_reg || drain_done);
    // pipeline advances unless a finished block waits at its end
    assign adv = !p_valid || take;
    assign blk.ready = adv;

    logic               s2_valid, s2_three;
    logic [1:0]         s2_fmt;
    palette_t           s2_pal;
    alpha_tab_t         s2_atab;
    logic [63:0]        s2_aw;
    logic [31:0]        s2_idx;

    bcd_palette u_pal (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(blk.valid), .fmt(fmt_reg),
        .alpha_word(blk.alpha_word), .color_word(blk.color_word),
        .out_valid(s2_valid), .out_fmt(s2_fmt), .out_three(s2_three),
        .out_pal(s2_pal), .out_atab(s2_atab),
        .out_alpha_word(s2_aw), .out_idx(s2_idx)
    );

    bcd_pixel u_pix (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(s2_valid), .fmt(s2_fmt), .three(s2_three),
        .pal(s2_pal), .atab(s2_atab), .alpha_word(s2_aw), .idx(s2_idx),
        .out_valid(p_valid), .out_pix(p_pix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= 1'b1;
                row_reg  <= 2'd0;
            end
            else if (row.valid && row.ready)
            begin
                row_reg <= row_reg + 2'd1;
                if (row_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            blk_reg <= p_pix;
        end
    end

    assign row.valid      = busy_reg;
    assign row.row_index  = row_reg;
    assign row.pixel_col0 = blk_reg[128*row_reg +  0 +: 32];
    assign row.pixel_col1 = blk_reg[128*row_reg + 32 +: 32];
    assign row.pixel_col2 = blk_reg[128*row_reg + 64 +: 32];
    assign row.pixel_col3 = blk_reg[128*row_reg + 96 +: 32];
    assign row.last_row   = (row_reg == 2'd3);
endmodule

/* design/bcd_palette.sv */
// Palette stage: endpoint expansion, colour palette and alpha table, two registered stages
`timescale 1ns / 1ps
module bcd_palette (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [1:0]          fmt,
    input  logic [63:0]         alpha_word,
    input  logic [63:0]         color_word,
    output logic                out_valid,
    output logic [1:0]          out_fmt,
    output logic                out_three,
    output bcd_pkg::palette_t   out_pal,
    output bcd_pkg::alpha_tab_t out_atab,
    output logic [63:0]         out_alpha_word,
    output logic [31:0]         out_idx
);
    import bcd_pkg::*;

    // stage 1: expanded endpoints
    logic        v1_reg;
    logic [1:0]  fmt1_reg;
    logic        three1_reg;
    rgb_t        c0_reg, c1_reg;
    logic [63:0] aw1_reg;
    logic [31:0] idx1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fmt1_reg   <= fmt;
            three1_reg <= (fmt == FMT_BC1) && (color_word[15:0] <= color_word[31:16]);
            c0_reg     <= expand565(color_word[15:0]);
            c1_reg     <= expand565(color_word[31:16]);
            aw1_reg    <= alpha_word;
            idx1_reg   <= color_word[63:32];
        end
    end

    // stage 2: palette and alpha table
    palette_t   pal_next;
    alpha_tab_t atab_next;
    logic [7:0] a0, a1;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            pal_next[0][ch] = c0_reg[ch];
            pal_next[1][ch] = c1_reg[ch];
            if (three1_reg)
            begin
                pal_next[2][ch] = chan_t'(({1'b0, c0_reg[ch]} + {1'b0, c1_reg[ch]}) >> 1);
                pal_next[3][ch] = 8'd0;
            end
            else
            begin
                pal_next[2][ch] = div3({1'b0, c0_reg[ch], 1'b0} + {2'b0, c1_reg[ch]});
                pal_next[3][ch] = div3({2'b0, c0_reg[ch]} + {1'b0, c1_reg[ch], 1'b0});
            end
        end
        a0 = aw1_reg[7:0];
        a1 = aw1_reg[15:8];
        atab_next[0] = a0;
        atab_next[1] = a1;
        if (a0 > a1)
        begin
            for (int i = 1; i <= 6; i++)
            begin
                atab_next[i + 1] = div7(11'((7 - i) * a0) + 11'(i * a1));
            end
        end
        else
        begin
            for (int i = 1; i <= 4; i++)
            begin
                atab_next[i + 1] = div5(11'((5 - i) * a0) + 11'(i * a1));
            end
            atab_next[6] = 8'd0;
            atab_next[7] = 8'd255;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_fmt        <= fmt1_reg;
            out_three      <= three1_reg;
            out_pal        <= pal_next;
            out_atab       <= atab_next;
            out_alpha_word <= aw1_reg;
            out_idx        <= idx1_reg;
        end
    end
endmodule

/* design/bcd_pixel.sv */
// Pixel stage: per-pixel colour and alpha selection for all sixteen pixels
`timescale 1ns / 1ps
module bcd_pixel (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [1:0]          fmt,
    input  logic                three,
    input  bcd_pkg::palette_t   pal,
    input  bcd_pkg::alpha_tab_t atab,
    input  logic [63:0]         alpha_word,
    input  logic [31:0]         idx,
    output logic                out_valid,
    output logic [511:0]        out_pix
);
    import bcd_pkg::*;

    logic [511:0] pix_next;
    logic [1:0]   ci;
    logic [7:0]   a;

    always_comb
    begin
        pix_next = '0;
        for (int p = 0; p < 16; p++)
        begin
            ci = idx[2*p +: 2];
            if (fmt == FMT_BC1)
            begin
                a = 8'd255;
            end
            else if (fmt == FMT_BC2)
            begin
                a = {alpha_word[4*p +: 4], alpha_word[4*p +: 4]};
            end
            else
            begin
                a = atab[alpha_word[16 + 3*p +: 3]];
            end
            if (three && ci == 2'd3)
            begin
                pix_next[32*p +: 32] = 32'd0;
            end
            else
            begin
                pix_next[32*p +: 32] = {a, pal[ci][2], pal[ci][1], pal[ci][0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pix <= pix_next;
        end
    end
endmodule

/* sim/bc1_bc2_bc3_block_decoder_top_tb.sv */
// Testbench: block decoder checked row by row against a built-in block predictor
`timescale 1ns / 1ps
module bc1_bc2_bc3_block_decoder_top_tb;
    import bcd_pkg::*;

    typedef struct {
        logic [1:0]  row_index;
        logic [31:0] col [4];
        logic        last_row;
    } row_item_t;

    class row_scoreboard;
        logic [1:0] fmt;
        row_item_t  pending[$];
        int         errors;

        function void note_block(logic [63:0] aw, logic [63:0] cw);
            logic [7:0]  pal [4][3];
            logic [7:0]  atab [8];
            logic [15:0] e0, e1;
            logic [9:0]  s;
            logic [1:0]  idx;
            logic [7:0]  a;
            logic [31:0] px [16];
            bit          three;
            row_item_t   r;
            int          p;
            e0 = cw[15:0];
            e1 = cw[31:16];
            three = (fmt == FMT_BC1) && (e0 <= e1);
            pal[0][0] = {e0[15:11], e0[15:13]};
            pal[0][1] = {e0[10:5], e0[10:9]};
            pal[0][2] = {e0[4:0], e0[4:2]};
            pal[1][0] = {e1[15:11], e1[15:13]};
            pal[1][1] = {e1[10:5], e1[10:9]};
            pal[1][2] = {e1[4:0], e1[4:2]};
            for (int ch = 0; ch < 3; ch++)
            begin
                if (three)
                begin
                    s = pal[0][ch] + pal[1][ch];
                    pal[2][ch] = 8'(s / 2);
                    pal[3][ch] = 8'd0;
                end
                else
                begin
                    pal[2][ch] = 8'((2 * int'(pal[0][ch]) + int'(pal[1][ch])) / 3);
                    pal[3][ch] = 8'((int'(pal[0][ch]) + 2 * int'(pal[1][ch])) / 3);
                end
            end
            atab[0] = aw[7:0];
            atab[1] = aw[15:8];
            if (aw[7:0] > aw[15:8])
                for (int i = 1; i <= 6; i++)
                    atab[i + 1] = 8'(((7 - i) * int'(aw[7:0]) + i * int'(aw[15:8])) / 7);
            else
            begin
                for (int i = 1; i <= 4; i++)
                    atab[i + 1] = 8'(((5 - i) * int'(aw[7:0]) + i * int'(aw[15:8])) / 5);
                atab[6] = 8'd0;
                atab[7] = 8'd255;
            end
            for (p = 0; p < 16; p++)
            begin
                idx = cw[32 + 2 * p +: 2];
                if (fmt == FMT_BC1)
                    a = 8'd255;
                else if (fmt == FMT_BC2)
                    a = aw[4 * p +: 4] * 8'd17;
                else
                    a = atab[aw[16 + 3 * p +: 3]];
                if (three && idx == 2'd3)
                    px[p] = 32'd0;
                else
                    px[p] = {a, pal[idx][2], pal[idx][1], pal[idx][0]};
            end
            for (int k = 0; k < 4; k++)
            begin
                r.row_index = 2'(k);
                for (int c = 0; c < 4; c++)
                    r.col[c] = px[4 * k + c];
                r.last_row = (k == 3);
                pending.push_back(r);
            end
        endfunction

        function void check_row(row_item_t got);
            row_item_t w;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected row %0d", $time, got.row_index);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.row_index !== w.row_index || got.last_row !== w.last_row)
            begin
                $display("%0t: row/last exp %0d/%0b got %0d/%0b", $time,
                         w.row_index, w.last_row, got.row_index, got.last_row);
                errors++;
            end
            for (int c = 0; c < 4; c++)
                if (got.col[c] !== w.col[c])
                begin
                    $display("%0t: row %0d col %0d exp %h got %h", $time,
                             w.row_index, c, w.col[c], got.col[c]);
                    errors++;
                end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bcd_cfg_if   cfg ();
    bcd_block_if blk ();
    bcd_row_if   row ();
    row_scoreboard board;
    int gap_left;

    bc1_bc2_bc3_block_decoder_top dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg.sink),
        .blk  (blk.sink),
        .row  (row.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("bc1_bc2_bc3_block_decoder_top_tb: errors");
        $finish;
    end

    // receiver: ready throughout one time window in three, randomly stalled in the others
    initial
    begin
        row.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (($time / 2000) % 3 == 0)
                row.ready <= 1'b1;
            else
                row.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        row_item_t got;
        if (rst_n && row.valid && row.ready)
        begin
            got.row_index = row.row_index;
            got.col[0] = row.pixel_col0;
            got.col[1] = row.pixel_col1;
            got.col[2] = row.pixel_col2;
            got.col[3] = row.pixel_col3;
            got.last_row = row.last_row;
            board.check_row(got);
        end
    end

    task automatic wait_drained();
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_format(logic [1:0] f);
        cfg.valid <= 1'b1;
        cfg.data  <= f;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        board.fmt = f;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // burst gaps: hold valid low for a random stretch before some items
    task automatic send_block(logic [63:0] aw, logic [63:0] cw);
        if (gap_left == 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                blk.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            gap_left = $urandom_range(1, 12);
        end
        gap_left--;
        blk.valid      <= 1'b1;
        blk.alpha_word <= aw;
        blk.color_word <= cw;
        @(posedge clk);
        while (!blk.ready)
            @(posedge clk);
        board.note_block(aw, cw);
        @(negedge clk);
    endtask

    task automatic idle_sender();
        blk.valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [63:0] aw, cw;
        logic [1:0]  fmts [5];
        board = new();
        board.fmt = FMT_BC3;
        gap_left = 0;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = 2'd0;
        blk.valid = 1'b0;
        blk.alpha_word = 64'd0;
        blk.color_word = 64'd0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset format, extremes and both alpha orderings
        send_block(64'd0, 64'd0);
        send_block('1, '1);
        send_block(64'h0000_0000_0000_40C0, 64'hE4E4_E4E4_F800_07E0);
        send_block(64'hFFFF_FFFF_FFFF_C040, 64'h1B1B_1B1B_001F_FFFF);
        idle_sender();
        wait_drained();

        fmts = '{FMT_BC1, FMT_BC2, 2'd3, FMT_BC3, FMT_BC1};
        foreach (fmts[f])
        begin
            write_format(fmts[f]);
            // four-colour and three-colour endpoint orders, equal endpoints
            send_block(64'h0123_4567_89AB_CDEF, 64'hE4E4_E4E4_1234_F00D);
            send_block(64'hFEDC_BA98_7654_3210, 64'hFFFF_FFFF_F00D_1234);
            send_block(64'hAAAA_5555_AAAA_0505, 64'h5555_AAAA_ABCD_ABCD);
            for (int n = 0; n < 30; n++)
            begin
                aw = rand64();
                cw = rand64();
                if ($urandom_range(0, 3) == 0)
                    cw[31:16] = cw[15:0];
                if ($urandom_range(0, 3) == 0)
                    aw[15:8] = aw[7:0];
                send_block(aw, cw);
            end
            idle_sender();
            wait_drained();
        end

        wait_drained();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("bc1_bc2_bc3_block_decoder_top_tb: clean");
        else
            $display("bc1_bc2_bc3_block_decoder_top_tb: errors");
        $finish;
    end
endmodule
